@@ hw/rtl/mpsc_pkg.sv @@
// ---------------------------------------------------------------------------
// Motor position stall controller package
// Command and drive codes, register indexes and field widths shared by the
// controller RTL.
// ---------------------------------------------------------------------------
package mpsc_pkg;

   localparam int unsigned DATA_WIDTH  = 32;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 72;

   typedef enum logic [1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_CONTROL    = 2'd1,
      CMD_SET_TARGET = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DRIVE_STOP    = 2'd0,
      DRIVE_FORWARD = 2'd1,
      DRIVE_REVERSE = 2'd2
   } drive_type;

   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EFFORT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_SPEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BACKOFF_STEP = 3'd5;

   localparam logic [9:0]  RST_DEADBAND     = 10'd2;
   localparam logic [7:0]  RST_SETTLE_TICKS = 8'd100;
   localparam logic [15:0] RST_TICK_RATE    = 16'd1000;
   localparam logic [14:0] RST_EFFORT_LIMIT = 15'd10000;
   localparam logic [9:0]  RST_STALL_SPEED  = 10'd20;
   localparam logic [9:0]  RST_BACKOFF_STEP = 10'd50;

endpackage

@@ hw/rtl/motor_position_stall_controller_top.sv @@
// ---------------------------------------------------------------------------
// Motor position stall controller
// Bang-bang position control of one axis with deadband, effort ramp, speed
// estimate and stall back-off.
// ---------------------------------------------------------------------------
//  Channel  Direction  Ports                         Content
//  req      in         req_tvalid/tready/tdata/tuser sample, control or target
//  rsp      out        rsp_tvalid/tready/tdata       drive, flags, speed, target
//  csr      in         csr_we/csr_index/csr_wdata    six control registers
//
// One transaction per cycle sustained while the result side is not stalled.
// Each request is captured in an input register and later fully processed;
// the state and the result register then update together. The speed update
// (one 32x16 multiply, subtract, shift, subtract) sets the critical path.
// Reset is synchronous and restores the state and register defaults.
// A stalled result holds the result register; the input register still takes
// one more request before req_tready drops.
// ---------------------------------------------------------------------------
module motor_position_stall_controller_top #(
   parameter int unsigned POS_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] position, [63:32] target
   input  logic [mpsc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] cmd
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] drive, [2] busy_res, [3] stalled, [35:4] speed, [67:36] reference
   output logic [mpsc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [mpsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mpsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned EXT_SHIFT = mpsc_pkg::DATA_WIDTH - POS_WIDTH;

   function automatic logic signed [31:0] pos_ext(input logic [31:0] x);
      logic [31:0] shifted;
      shifted = x << EXT_SHIFT;
      return $signed(shifted) >>> EXT_SHIFT;
   endfunction

   // Control registers
   logic [9:0]  deadband_ff;
   logic [7:0]  settle_ticks_ff;
   logic [15:0] tick_rate_ff;
   logic [14:0] effort_limit_ff;
   logic [9:0]  stall_speed_ff;
   logic [9:0]  backoff_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff     <= mpsc_pkg::RST_DEADBAND;
         settle_ticks_ff <= mpsc_pkg::RST_SETTLE_TICKS;
         tick_rate_ff    <= mpsc_pkg::RST_TICK_RATE;
         effort_limit_ff <= mpsc_pkg::RST_EFFORT_LIMIT;
         stall_speed_ff  <= mpsc_pkg::RST_STALL_SPEED;
         backoff_step_ff <= mpsc_pkg::RST_BACKOFF_STEP;
      end else if (csr_we) begin
         case (csr_index)
            mpsc_pkg::REG_DEADBAND:     deadband_ff     <= csr_wdata[9:0];
            mpsc_pkg::REG_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[7:0];
            mpsc_pkg::REG_TICK_RATE:    tick_rate_ff    <= csr_wdata[15:0];
            mpsc_pkg::REG_EFFORT_LIMIT: effort_limit_ff <= csr_wdata[14:0];
            mpsc_pkg::REG_STALL_SPEED:  stall_speed_ff  <= csr_wdata[9:0];
            mpsc_pkg::REG_BACKOFF_STEP: backoff_step_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                  in_vld_ff;
   mpsc_pkg::cmd_type     in_cmd_ff;
   logic [31:0]           in_pos_ff;
   logic [31:0]           in_tgt_ff;
   logic                  rsp_vld_ff;
   logic                  fire;

   assign fire       = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= mpsc_pkg::cmd_type'(req_tuser);
         in_pos_ff <= req_tdata[31:0];
         in_tgt_ff <= req_tdata[63:32];
      end
   end

   // Controller state
   logic signed [31:0] goal_ff, goal_in;
   logic signed [31:0] last_pos_ff, last_pos_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [15:0] effort_ff, effort_in;
   logic [7:0]         timer_ff, timer_in;
   mpsc_pkg::drive_type drive_ff, drive_in;
   logic               stalled_in;

   logic signed [31:0] pos;
   logic [31:0]        delta;
   logic [31:0]        prod_full;
   logic signed [31:0] speed_diff;
   logic signed [31:0] err;
   logic signed [31:0] db;
   logic signed [31:0] ss;
   logic signed [15:0] lim;
   logic [31:0]        backoff_pos;

   always_comb begin
      pos        = pos_ext(in_pos_ff);
      delta      = pos - last_pos_ff;
      prod_full  = delta * {16'd0, tick_rate_ff};
      speed_diff = speed_ff - $signed(prod_full);
      err        = goal_ff - pos;
      db         = $signed({22'd0, deadband_ff});
      ss         = $signed({22'd0, stall_speed_ff});
      lim        = $signed({1'b0, effort_limit_ff});
      // Back off away from the direction the target lay in.
      backoff_pos = (pos < goal_ff) ? (pos - {22'd0, backoff_step_ff})
                                    : (pos + {22'd0, backoff_step_ff});

      goal_in     = goal_ff;
      last_pos_in = last_pos_ff;
      speed_in    = speed_ff;
      effort_in   = effort_ff;
      timer_in    = timer_ff;
      drive_in    = drive_ff;
      stalled_in  = 1'b0;

      case (in_cmd_ff)
         mpsc_pkg::CMD_SAMPLE: begin
            speed_in    = speed_ff - (speed_diff >>> 3);
            last_pos_in = pos;
         end
         mpsc_pkg::CMD_CONTROL: begin
            if (err > db) begin
               drive_in = mpsc_pkg::DRIVE_FORWARD;
               timer_in = settle_ticks_ff;
               if (effort_ff < lim) begin
                  effort_in = effort_ff + 16'sd1;
               end else if (speed_ff < ss) begin
                  stalled_in = 1'b1;
               end
            end else if (err < -db) begin
               drive_in = mpsc_pkg::DRIVE_REVERSE;
               timer_in = settle_ticks_ff;
               if (effort_ff > -lim) begin
                  effort_in = effort_ff - 16'sd1;
               end else if (speed_ff > -ss) begin
                  stalled_in = 1'b1;
               end
            end else begin
               drive_in  = mpsc_pkg::DRIVE_STOP;
               timer_in  = (timer_ff != 8'd0) ? timer_ff - 8'd1 : timer_ff;
               effort_in = effort_ff - (effort_ff >>> 3);
            end
            if (stalled_in) begin
               goal_in  = pos_ext(backoff_pos);
               drive_in = mpsc_pkg::DRIVE_STOP;
            end
         end
         mpsc_pkg::CMD_SET_TARGET: begin
            goal_in = pos_ext(in_tgt_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff     <= '0;
         last_pos_ff <= '0;
         speed_ff    <= '0;
         effort_ff   <= '0;
         timer_ff    <= '0;
         drive_ff    <= mpsc_pkg::DRIVE_STOP;
      end else if (fire) begin
         goal_ff     <= goal_in;
         last_pos_ff <= last_pos_in;
         speed_ff    <= speed_in;
         effort_ff   <= effort_in;
         timer_ff    <= timer_in;
         drive_ff    <= drive_in;
      end
   end

   // Result register
   logic [1:0]  rsp_drive_ff;
   logic        rsp_busy_ff;
   logic        rsp_stalled_ff;
   logic [31:0] rsp_speed_ff;
   logic [31:0] rsp_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (fire) begin
         rsp_drive_ff   <= drive_in;
         rsp_busy_ff    <= (timer_in != 8'd0);
         rsp_stalled_ff <= stalled_in;
         rsp_speed_ff   <= speed_in;
         rsp_ref_ff     <= goal_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_ref_ff, rsp_speed_ff, rsp_stalled_ff, rsp_busy_ff,
                        rsp_drive_ff};

   // A stall always ends the drive.
   a_stall_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stalled_ff |-> rsp_drive_ff == mpsc_pkg::DRIVE_STOP)
      else $error("stall result with active drive");

   // The input side only backs up when both stages are full and blocked.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_vld_ff && rsp_vld_ff && !rsp_tready)
      else $error("request side stalled without a full pipeline");

   // A new result only appears after a request was processed.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(fire))
      else $error("result appeared without a processed request");

   // The stall flag is only raised by a control step.
   a_stall_cmd: assert property (@(posedge clock) disable iff (reset)
      fire && stalled_in |-> in_cmd_ff == mpsc_pkg::CMD_CONTROL)
      else $error("stall flagged outside a control step");

endmodule
